@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/dtlv_pkg.sv @@
// ----------------------------------------------------------------------------
// dtlv_pkg
// Types and constants shared by the DER TLV header parser.
// ----------------------------------------------------------------------------
package dtlv_pkg;

   localparam int MAX_LENGTH_BYTES_DEFAULT = 4;
   localparam int TDATA_W = 80;
   localparam int TUSER_W = 2;

   localparam logic [7:0] LONG_FORM_BIT = 8'h80;

   typedef enum logic [1:0] {
      ROLE_TAG     = 2'd0,
      ROLE_LEN1    = 2'd1,
      ROLE_LENX    = 2'd2,
      ROLE_PAYLOAD = 2'd3
   } role_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TRUNCATED = 2'd1,
      ERR_TOO_LONG  = 2'd2
   } err_type;

   typedef struct packed {
      role_type    role;
      logic [7:0]  tag;
      logic [31:0] len;
      logic [31:0] pidx;
      logic        hdone;
      logic        edone;
      err_type     err;
   } result_type;

endpackage

@@ design/dtlv_core.sv @@
// ----------------------------------------------------------------------------
// dtlv_core
// Parser state and the per-byte decode: tag, length forms, payload count,
// truncation and skip-to-end handling.
// ----------------------------------------------------------------------------
module dtlv_core
   import dtlv_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] in_byte,
   input  logic       eob,
   output result_type res
);

   localparam int LEFT_W = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
   localparam logic [6:0] MAX_N = 7'(MAX_LENGTH_BYTES);

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN1,
      PH_LENX,
      PH_PAYLOAD
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [7:0]        tag_ff, tag_in;
   logic [31:0]       accum_ff, accum_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [31:0]       count_ff, count_in;
   logic              skip_ff, skip_in;

   logic [6:0]  long_n;
   logic [31:0] accum_shift;
   logic [31:0] count_next;

   assign long_n      = in_byte[6:0];
   assign accum_shift = {accum_ff[23:0], in_byte};
   assign count_next  = count_ff + 32'd1;

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      accum_in = accum_ff;
      left_in  = left_ff;
      count_in = count_ff;
      skip_in  = skip_ff;
      res      = '0;
      if (skip_ff) begin
         if (eob) begin
            skip_in  = 1'b0;
            phase_in = PH_TAG;
            left_in  = '0;
         end
      end else begin
         case (phase_ff)
            PH_TAG: begin
               tag_in   = in_byte;
               res.role = ROLE_TAG;
               res.tag  = in_byte;
               phase_in = PH_LEN1;
               if (eob) begin
                  res.err  = ERR_TRUNCATED;
                  phase_in = PH_TAG;
                  left_in  = '0;
               end
            end
            PH_LEN1: begin
               res.role = ROLE_LEN1;
               res.tag  = tag_ff;
               if ((in_byte & LONG_FORM_BIT) == 8'h00) begin
                  accum_in  = {24'd0, in_byte};
                  res.len   = {24'd0, in_byte};
                  res.hdone = 1'b1;
                  if (in_byte == 8'h00) begin
                     res.edone = 1'b1;
                     phase_in  = PH_TAG;
                     left_in   = '0;
                  end else begin
                     count_in = '0;
                     phase_in = PH_PAYLOAD;
                     if (eob) begin
                        res.err  = ERR_TRUNCATED;
                        phase_in = PH_TAG;
                        left_in  = '0;
                     end
                  end
               end else begin
                  accum_in = '0;
                  if (long_n > MAX_N) begin
                     res.err  = ERR_TOO_LONG;
                     phase_in = PH_TAG;
                     left_in  = '0;
                     if (!eob) begin
                        skip_in = 1'b1;
                     end
                  end else if (long_n == 7'd0) begin
                     res.hdone = 1'b1;
                     res.edone = 1'b1;
                     phase_in  = PH_TAG;
                     left_in   = '0;
                  end else begin
                     left_in  = LEFT_W'(long_n - 7'd1);
                     phase_in = PH_LENX;
                     if (eob) begin
                        res.err  = ERR_TRUNCATED;
                        phase_in = PH_TAG;
                        left_in  = '0;
                     end
                  end
               end
            end
            PH_LENX: begin
               res.role = ROLE_LENX;
               res.tag  = tag_ff;
               accum_in = accum_shift;
               if (left_ff == '0) begin
                  res.len   = accum_shift;
                  res.hdone = 1'b1;
                  if (accum_shift == 32'd0) begin
                     res.edone = 1'b1;
                     phase_in  = PH_TAG;
                     left_in   = '0;
                  end else begin
                     count_in = '0;
                     phase_in = PH_PAYLOAD;
                     if (eob) begin
                        res.err  = ERR_TRUNCATED;
                        phase_in = PH_TAG;
                        left_in  = '0;
                     end
                  end
               end else begin
                  left_in = left_ff - LEFT_W'(1);
                  if (eob) begin
                     res.err  = ERR_TRUNCATED;
                     phase_in = PH_TAG;
                     left_in  = '0;
                  end
               end
            end
            PH_PAYLOAD: begin
               res.role = ROLE_PAYLOAD;
               res.tag  = tag_ff;
               res.len  = accum_ff;
               res.pidx = count_ff;
               count_in = count_next;
               if (count_next == accum_ff) begin
                  res.edone = 1'b1;
                  phase_in  = PH_TAG;
                  left_in   = '0;
               end else if (eob) begin
                  res.err  = ERR_TRUNCATED;
                  phase_in = PH_TAG;
                  left_in  = '0;
               end
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         tag_ff   <= '0;
         accum_ff <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         skip_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

@@ design/der_tlv_header_parser.sv @@
// ----------------------------------------------------------------------------
// der_tlv_header_parser
// Walks a byte stream of flat DER elements and reports, for every byte,
// its role and the header information of the element it belongs to.
//
//   Channel  Direction  Carries
//   req_*    in         one buffer byte, tlast marks the buffer end
//   rsp_*    out        one decode result per byte, tlast is element done
//
// One byte is taken per cycle while rsp is not stalled; the decode sits
// between the input register and the result register, so a byte's result
// is registered when the parser advances and then leaves on rsp. The
// parser state updates together with the result register.
// Synchronous reset returns the parser to the tag phase and empties both
// registers. A stalled result holds while the input register still takes
// one more byte.
// ----------------------------------------------------------------------------
module der_tlv_header_parser
   import dtlv_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // in_byte
   input  logic               req_tlast,   // end_of_buffer
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // tag_value, element_length,
                                           // payload_index, header_done,
                                           // error_code, zero fill
   output logic [TUSER_W-1:0] rsp_tuser,   // role
   output logic               rsp_tlast    // element_done
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type res_ff;
   result_type res;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   dtlv_core #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .in_byte(in_byte_ff),
      .eob    (in_last_ff),
      .res    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.err, res_ff.hdone, res_ff.pidx, res_ff.len, res_ff.tag};
   assign rsp_tuser  = res_ff.role;
   assign rsp_tlast  = res_ff.edone;

endmodule

@@ design/dtlv_checker.sv @@
// ----------------------------------------------------------------------------
// dtlv_checker
// Port-level checks for the DER TLV header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtlv_checker
   import dtlv_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata,
   input logic [TUSER_W-1:0] rsp_tuser,
   input logic               rsp_tlast
);

   `ASSERT_CLK(a_rsp_hold, clock, reset,
               rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
               $stable(rsp_tuser) && $stable(rsp_tlast),
               "result changed while stalled")
   `ASSERT_CLK(a_hdone_role, clock, reset,
               rsp_tvalid && rsp_tdata[72] |-> rsp_tuser == ROLE_LEN1 ||
               rsp_tuser == ROLE_LENX,
               "header done on a byte that is not a length byte")
   `ASSERT_NEVER(a_tag_edone, clock, reset,
                 rsp_tvalid && rsp_tlast && rsp_tuser == ROLE_TAG,
                 "element done on a tag byte")
   `ASSERT_CLK(a_done_no_err, clock, reset,
               rsp_tvalid && rsp_tlast |-> rsp_tdata[74:73] == ERR_NONE,
               "element done together with an error")

endmodule

bind der_tlv_header_parser dtlv_checker u_dtlv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
